### hdl/irpd_pkg.sv
// Types and constants shared by the IR pulse-distance frame encoder.
package irpd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] bit_count;
        logic       frame_first;
        logic       frame_last;
    } t_in_word;

    typedef struct packed {
        logic        level;
        logic [15:0] duration_us;
        logic        run_end;
    } t_out_word;

    // Classified byte handed from front to back; count already saturated.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] count;
        logic       first;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [15:0] header_mark_us;
        logic [15:0] header_space_us;
        logic [15:0] bit_mark_us;
        logic [15:0] one_space_us;
        logic [15:0] zero_space_us;
        logic [15:0] trailer_mark_us;
        logic [15:0] trailer_space_us;
        logic        separator_enable;
    } t_cfg;

    typedef struct packed {
        logic       busy;
        logic       emit;
        logic       emit_end;
        logic [4:0] pos;
    } t_back_status;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SPACE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_MARK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_SPACE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR     = 3'd7;

    localparam logic [15:0] RST_HEADER_MARK   = 16'd3500;
    localparam logic [15:0] RST_HEADER_SPACE  = 16'd3500;
    localparam logic [15:0] RST_BIT_MARK      = 16'd900;
    localparam logic [15:0] RST_ONE_SPACE     = 16'd2600;
    localparam logic [15:0] RST_ZERO_SPACE    = 16'd900;
    localparam logic [15:0] RST_TRAILER_MARK  = 16'd900;
    localparam logic [15:0] RST_TRAILER_SPACE = 16'd13900;
    localparam logic        RST_SEPARATOR     = 1'b1;

    localparam logic [3:0] MAX_BITS = 4'd8;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

endpackage

### hdl/irpd_front.sv
// Front end: accepts input words, saturates the bit count, drops words with no result.
module irpd_front (
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  irpd_pkg::t_in_word i_in_word,
    input  logic               i_q_full,
    output logic               o_push,
    output irpd_pkg::t_cmd     o_cmd
);

    logic [3:0] w_count;
    logic       w_has_result;

    always_comb begin
        if (i_in_word.bit_count > irpd_pkg::MAX_BITS) begin
            w_count = irpd_pkg::MAX_BITS;
        end else begin
            w_count = i_in_word.bit_count;
        end
        w_has_result = (w_count != 4'd0) || i_in_word.frame_first || i_in_word.frame_last;
    end

    assign o_in_stall       = i_q_full;
    assign o_push           = i_in_valid && !i_q_full && w_has_result;
    assign o_cmd.data_byte  = i_in_word.data_byte;
    assign o_cmd.count      = w_count;
    assign o_cmd.first      = i_in_word.frame_first;
    assign o_cmd.last       = i_in_word.frame_last;

endmodule

### hdl/irpd_queue.sv
// Two-entry command queue between front and back.
module irpd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  irpd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output irpd_pkg::t_cmd o_cmd
);

    irpd_pkg::t_cmd r_mem [irpd_pkg::Q_DEPTH];

    logic [irpd_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [irpd_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [irpd_pkg::Q_CNT_W-1:0] r_count;
    logic [irpd_pkg::Q_PTR_W-1:0] n_wr_ptr;
    logic [irpd_pkg::Q_PTR_W-1:0] n_rd_ptr;
    logic [irpd_pkg::Q_CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == irpd_pkg::Q_CNT_W'(irpd_pkg::Q_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

### hdl/irpd_back.sv
// Back end: walks one command through header, bits, separators and trailer.
module irpd_back #(
    parameter int GROUP_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  irpd_pkg::t_cfg          i_cfg,
    input  logic                    i_q_valid,
    input  irpd_pkg::t_cmd          i_q_cmd,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output irpd_pkg::t_out_word     o_out_word,
    output irpd_pkg::t_back_status  o_status
);

    localparam logic [4:0] LAST_POS = 5'(GROUP_BITS - 1);

    localparam logic [2:0] PH_HDR_MARK  = 3'd0;
    localparam logic [2:0] PH_HDR_SPACE = 3'd1;
    localparam logic [2:0] PH_BIT_MARK  = 3'd2;
    localparam logic [2:0] PH_BIT_SPACE = 3'd3;
    localparam logic [2:0] PH_TRL_MARK  = 3'd4;
    localparam logic [2:0] PH_TRL_SPACE = 3'd5;

    logic                r_busy,      n_busy;
    logic [2:0]          r_phase,     n_phase;
    logic [7:0]          r_data,      n_data;
    logic [3:0]          r_left,      n_left;
    logic                r_last,      n_last;
    logic [4:0]          r_pos,       n_pos;
    logic                r_out_valid, n_out_valid;
    irpd_pkg::t_out_word r_out,       n_out;

    logic       w_adv;
    logic       w_emit;
    logic       w_pop;
    logic       w_after;
    logic       w_end;
    logic [3:0] w_left_next;

    assign w_adv  = !r_out_valid || !i_out_stall;
    assign w_emit = r_busy && w_adv;
    assign w_pop  = !r_busy && i_q_valid;

    always_comb begin
        n_busy      = r_busy;
        n_phase     = r_phase;
        n_data      = r_data;
        n_left      = r_left;
        n_last      = r_last;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_after     = 1'b0;
        w_end       = 1'b0;
        w_left_next = r_left;

        if (w_pop) begin
            n_busy = 1'b1;
            n_data = i_q_cmd.data_byte;
            n_left = i_q_cmd.count;
            n_last = i_q_cmd.last;
            if (i_q_cmd.first) begin
                n_pos   = '0;
                n_phase = PH_HDR_MARK;
            end else if (i_q_cmd.count != 4'd0) begin
                n_phase = PH_BIT_MARK;
            end else begin
                n_phase = PH_TRL_MARK;
            end
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
            case (r_phase)
                PH_HDR_MARK: begin
                    n_out.level       = 1'b1;
                    n_out.duration_us = i_cfg.header_mark_us;
                    n_phase           = PH_HDR_SPACE;
                end
                PH_HDR_SPACE: begin
                    n_out.level       = 1'b0;
                    n_out.duration_us = i_cfg.header_space_us;
                    w_after           = 1'b1;
                end
                PH_BIT_MARK: begin
                    n_out.level       = 1'b1;
                    n_out.duration_us = i_cfg.bit_mark_us;
                    n_phase           = PH_BIT_SPACE;
                end
                PH_BIT_SPACE: begin
                    n_out.level       = 1'b0;
                    n_out.duration_us = r_data[7] ? i_cfg.one_space_us
                                                  : i_cfg.zero_space_us;
                    n_data            = {r_data[6:0], 1'b0};
                    w_left_next       = r_left - 4'd1;
                    n_left            = w_left_next;
                    if (r_pos == LAST_POS) begin
                        n_pos = '0;
                        if (i_cfg.separator_enable) begin
                            n_phase = PH_HDR_MARK;
                        end else begin
                            w_after = 1'b1;
                        end
                    end else begin
                        n_pos   = r_pos + 5'd1;
                        w_after = 1'b1;
                    end
                end
                PH_TRL_MARK: begin
                    n_out.level       = 1'b1;
                    n_out.duration_us = i_cfg.trailer_mark_us;
                    n_phase           = PH_TRL_SPACE;
                end
                PH_TRL_SPACE: begin
                    n_out.level       = 1'b0;
                    n_out.duration_us = i_cfg.trailer_space_us;
                    w_end             = 1'b1;
                end
                default: begin
                    n_out.level       = 1'b0;
                    n_out.duration_us = '0;
                    w_end             = 1'b1;
                end
            endcase

            if (w_after) begin
                if (w_left_next != 4'd0) begin
                    n_phase = PH_BIT_MARK;
                end else if (r_last) begin
                    n_phase = PH_TRL_MARK;
                end else begin
                    w_end = 1'b1;
                end
            end

            n_out.run_end = w_end;
            if (w_end) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_HDR_MARK;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_left <= n_left;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_q_pop           = w_pop;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;
    assign o_status.busy     = r_busy;
    assign o_status.emit     = w_emit;
    assign o_status.emit_end = w_end;
    assign o_status.pos      = r_pos;

endmodule

### hdl/ir_pulse_distance_frame_encoder.sv
// Top level of the IR pulse-distance frame encoder: config registers, front, queue, back.
//
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_stall    i_in_word  (irpd_pkg::t_in_word)
//  out      output     o_out_valid / i_out_stall  o_out_word (irpd_pkg::t_out_word)
//  cfg      input      i_cfg_we                   i_cfg_index, i_cfg_wdata
//
// A byte yielding n durations occupies the back end for a load step from the queue, then
// one duration per cycle unless output stalls; n is at most 20 when GROUP_BITS is 32.
// The back-end sequencer, one duration per cycle unless output stalls, sets the rate.
// The front keeps accepting words into a two-entry queue while the back end works.
// Output stall freezes the sequencer; input stall is raised only when the queue is full.
// Reset is synchronous, active low, and restores register defaults and group position.
module ir_pulse_distance_frame_encoder #(
    parameter int GROUP_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  irpd_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output irpd_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [irpd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    irpd_pkg::t_cfg         r_cfg;
    irpd_pkg::t_cmd         w_push_cmd;
    irpd_pkg::t_cmd         w_q_cmd;
    irpd_pkg::t_back_status w_status;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_q_valid;
    logic                   w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mark_us   <= irpd_pkg::RST_HEADER_MARK;
            r_cfg.header_space_us  <= irpd_pkg::RST_HEADER_SPACE;
            r_cfg.bit_mark_us      <= irpd_pkg::RST_BIT_MARK;
            r_cfg.one_space_us     <= irpd_pkg::RST_ONE_SPACE;
            r_cfg.zero_space_us    <= irpd_pkg::RST_ZERO_SPACE;
            r_cfg.trailer_mark_us  <= irpd_pkg::RST_TRAILER_MARK;
            r_cfg.trailer_space_us <= irpd_pkg::RST_TRAILER_SPACE;
            r_cfg.separator_enable <= irpd_pkg::RST_SEPARATOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                irpd_pkg::CFG_HEADER_MARK:   r_cfg.header_mark_us   <= i_cfg_wdata;
                irpd_pkg::CFG_HEADER_SPACE:  r_cfg.header_space_us  <= i_cfg_wdata;
                irpd_pkg::CFG_BIT_MARK:      r_cfg.bit_mark_us      <= i_cfg_wdata;
                irpd_pkg::CFG_ONE_SPACE:     r_cfg.one_space_us     <= i_cfg_wdata;
                irpd_pkg::CFG_ZERO_SPACE:    r_cfg.zero_space_us    <= i_cfg_wdata;
                irpd_pkg::CFG_TRAILER_MARK:  r_cfg.trailer_mark_us  <= i_cfg_wdata;
                irpd_pkg::CFG_TRAILER_SPACE: r_cfg.trailer_space_us <= i_cfg_wdata;
                irpd_pkg::CFG_SEPARATOR:     r_cfg.separator_enable <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    irpd_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    irpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_cmd   (w_q_cmd)
    );

    irpd_back #(
        .GROUP_BITS (GROUP_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .o_status    (w_status)
    );

    a_pos_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.pos <= 5'(GROUP_BITS - 1))
        else $error("group position past end of group");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.emit && w_status.emit_end) |=> !w_status.busy)
        else $error("back end still busy after last duration of a byte");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!w_status.busy && !w_status.emit))
        else $error("queue popped while a byte is in progress");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.emit |=> o_out_valid)
        else $error("emitted duration not presented on output");

endmodule
